// ===== rtl/fcpi_pkg.sv =====
// Shared types, constants and tables of the fly-camera pose integrator.
`default_nettype none
package fcpi_pkg;

   localparam int POS_BITS_DEF     = 32;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int CNT_BITS   = 5;
   localparam int REQ_W      = 64;
   localparam int RSP_W      = 240;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_LOOK_SENS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_SPEED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_YAW   = 2'd2;

   localparam logic [15:0]        SENS_RESET  = 16'd6554;
   localparam logic [14:0]        SPEED_RESET = 15'd1280;
   localparam logic signed [14:0] YAW_RESET   = -15'sd5760;

   localparam int YAW_SPAN   = 23040;
   localparam int YAW_HALF   = 11520;
   localparam int PITCH_LIM  = 5696;
   localparam int SPEED_MIN  = 128;
   localparam int SPEED_MAX  = 25600;
   localparam int ONE_Q14    = 16384;
   localparam int DEG90      = 5898240;
   localparam int DEG180     = 11796480;
   localparam int CORDIC_K   = 652032874;
   localparam int WRAP_STEPS = 8;
   localparam int MOVE_SLOTS = 14;
   localparam int BASIS_STEPS = 7;

   // Arctangent of 2^-i in 1/65536 degree.
   localparam logic [21:0] ATAN_TABLE [0:23] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOKX, ST_LOOKY, ST_PITCH, ST_WRAP, ST_WRAPEND,
      ST_CINIT, ST_CSTEP, ST_CEND, ST_BASIS, ST_VEL, ST_MMUL, ST_MADD,
      ST_SPEED, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CSR, OP_LOOKX, OP_LOOKY, OP_PITCH, OP_WRAP,
      OP_WRAPEND, OP_CINIT, OP_CSTEP, OP_CEND, OP_BASIS, OP_VEL, OP_MMUL,
      OP_MADD, OP_SPEED, OP_OUT
   } op_type;

   typedef enum logic [1:0] {VEC_FRONT, VEC_RIGHT, VEC_UNIT} vec_type;

   typedef struct packed {
      op_type              op;
      logic [CNT_BITS-1:0] cnt;
      logic                phase;
   } cmd_type;

   typedef struct packed {
      logic look_zero;
   } status_type;

   typedef struct packed {
      vec_type    kind;
      logic [1:0] axis;
      logic [2:0] key;
      logic       neg;
   } slot_type;

   // Order of moves: forward, back, left, right along three axes, then up, down.
   function automatic slot_type slot_info(input logic [3:0] slot);
      slot_type s;
      unique case (slot)
         4'd0:  s = '{VEC_FRONT, 2'd0, 3'd0, 1'b0};
         4'd1:  s = '{VEC_FRONT, 2'd1, 3'd0, 1'b0};
         4'd2:  s = '{VEC_FRONT, 2'd2, 3'd0, 1'b0};
         4'd3:  s = '{VEC_FRONT, 2'd0, 3'd1, 1'b1};
         4'd4:  s = '{VEC_FRONT, 2'd1, 3'd1, 1'b1};
         4'd5:  s = '{VEC_FRONT, 2'd2, 3'd1, 1'b1};
         4'd6:  s = '{VEC_RIGHT, 2'd0, 3'd2, 1'b1};
         4'd7:  s = '{VEC_RIGHT, 2'd1, 3'd2, 1'b1};
         4'd8:  s = '{VEC_RIGHT, 2'd2, 3'd2, 1'b1};
         4'd9:  s = '{VEC_RIGHT, 2'd0, 3'd3, 1'b0};
         4'd10: s = '{VEC_RIGHT, 2'd1, 3'd3, 1'b0};
         4'd11: s = '{VEC_RIGHT, 2'd2, 3'd3, 1'b0};
         4'd12: s = '{VEC_UNIT, 2'd1, 3'd4, 1'b0};
         4'd13: s = '{VEC_UNIT, 2'd1, 3'd5, 1'b1};
         default: s = '{VEC_UNIT, 2'd1, 3'd5, 1'b1};
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fcpi_ctrl.sv =====
// Sequencing state machine of the fly-camera pose integrator.
`default_nettype none
module fcpi_ctrl #(
   parameter int CORDIC_STEPS = fcpi_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fcpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire fcpi_pkg::status_type          status,
   output fcpi_pkg::cmd_type                  cmd
);
   import fcpi_pkg::*;

   localparam logic [CNT_BITS-1:0] CSTEP_LAST = CNT_BITS'(CORDIC_STEPS - 1);
   localparam logic [CNT_BITS-1:0] WRAP_LAST  = CNT_BITS'(WRAP_STEPS - 1);
   localparam logic [CNT_BITS-1:0] BASIS_LAST = CNT_BITS'(BASIS_STEPS - 1);
   localparam logic [CNT_BITS-1:0] MOVE_LAST  = CNT_BITS'(MOVE_SLOTS - 1);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                phase_ff, phase_in;
   logic                item_ff, item_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         // After reset the basis is built from the reset angles.
         state_ff     <= ST_CINIT;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         item_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         item_ff      <= item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      item_in  = item_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               if (csr_index == REG_START_YAW) begin
                  state_in = ST_CINIT;
                  phase_in = 1'b0;
                  item_in  = 1'b0;
               end
            end else if (req_tvalid) begin
               state_in = ST_LOOKX;
               item_in  = 1'b1;
            end
         end
         ST_LOOKX:  state_in = status.look_zero ? ST_VEL : ST_LOOKY;
         ST_LOOKY:  state_in = ST_PITCH;
         ST_PITCH: begin
            state_in = ST_WRAP;
            cnt_in   = '0;
         end
         ST_WRAP: begin
            if (cnt_ff == WRAP_LAST) begin
               state_in = ST_WRAPEND;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WRAPEND: begin
            state_in = ST_CINIT;
            phase_in = 1'b0;
         end
         ST_CINIT: begin
            state_in = ST_CSTEP;
            cnt_in   = '0;
         end
         ST_CSTEP: begin
            if (cnt_ff == CSTEP_LAST) begin
               state_in = ST_CEND;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CEND: begin
            if (!phase_ff) begin
               state_in = ST_CINIT;
               phase_in = 1'b1;
            end else begin
               state_in = ST_BASIS;
               cnt_in   = '0;
            end
         end
         ST_BASIS: begin
            if (cnt_ff == BASIS_LAST) begin
               state_in = item_ff ? ST_VEL : ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_VEL: begin
            state_in = ST_MMUL;
            cnt_in   = '0;
         end
         ST_MMUL:   state_in = ST_MADD;
         ST_MADD: begin
            if (cnt_ff == MOVE_LAST) begin
               state_in = ST_SPEED;
               cnt_in   = '0;
            end else begin
               state_in = ST_MMUL;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         ST_SPEED:  state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
               item_in  = 1'b0;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.cnt    = cnt_ff;
      cmd.phase  = phase_ff;
      cmd.op     = OP_NONE;
      csr_ready  = (state_ff == ST_IDLE);
      req_tready = (state_ff == ST_IDLE) && !csr_valid;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid)       cmd.op = OP_CSR;
            else if (req_tvalid) cmd.op = OP_LOAD;
         end
         ST_LOOKX:   cmd.op = OP_LOOKX;
         ST_LOOKY:   cmd.op = OP_LOOKY;
         ST_PITCH:   cmd.op = OP_PITCH;
         ST_WRAP:    cmd.op = OP_WRAP;
         ST_WRAPEND: cmd.op = OP_WRAPEND;
         ST_CINIT:   cmd.op = OP_CINIT;
         ST_CSTEP:   cmd.op = OP_CSTEP;
         ST_CEND:    cmd.op = OP_CEND;
         ST_BASIS:   cmd.op = OP_BASIS;
         ST_VEL:     cmd.op = OP_VEL;
         ST_MMUL:    cmd.op = OP_MMUL;
         ST_MADD:    cmd.op = OP_MADD;
         ST_SPEED:   cmd.op = OP_SPEED;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_OUT;
               out_load = 1'b1;
            end
         end
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/fcpi_datapath.sv =====
// Datapath of the fly-camera pose integrator: angles, CORDIC, basis, position, speed.
`default_nettype none
module fcpi_datapath #(
   parameter int POS_BITS = fcpi_pkg::POS_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire fcpi_pkg::cmd_type              cmd,
   output fcpi_pkg::status_type                status,
   input  wire logic [fcpi_pkg::REQ_W-1:0]      req_tdata,
   input  wire logic [fcpi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fcpi_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [fcpi_pkg::RSP_W-1:0]           rsp_tdata
);
   import fcpi_pkg::*;

   localparam int PS = POS_BITS + 2;
   localparam int PW = (POS_BITS > 32) ? POS_BITS : 32;
   localparam logic signed [PS-1:0] POS_HI = PS'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
   localparam logic signed [PS-1:0] POS_LO = -POS_HI - PS'(1);

   function automatic logic signed [15:0] q14_sat(input logic signed [32:0] v);
      logic signed [32:0] t;
      t = (v + 33'sd8192) >>> 14;
      if (t > 33'sd16384)       return 16'sd16384;
      else if (t < -33'sd16384) return -16'sd16384;
      else                      return 16'(t);
   endfunction

   function automatic logic signed [15:0] q16_sat(input logic signed [32:0] v);
      logic signed [32:0] t;
      t = (v + 33'sd32768) >>> 16;
      if (t > 33'sd16384)       return 16'sd16384;
      else if (t < -33'sd16384) return -16'sd16384;
      else                      return 16'(t);
   endfunction

   // Captured frame fields.
   logic signed [15:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [5:0]         keys_ff, keys_in;
   logic signed [7:0]  scroll_ff, scroll_in;
   logic [15:0]        dt_ff, dt_in;

   // Pose state.
   logic [15:0]          sens_ff, sens_in;
   logic signed [14:0]   yaw_ff, yaw_in;
   logic signed [13:0]   pitch_ff, pitch_in;
   logic [14:0]          speed_ff, speed_in;
   logic signed [POS_BITS-1:0] pos_ff [3];
   logic signed [POS_BITS-1:0] pos_in [3];

   // Working registers.
   logic signed [32:0] prod_ff, prod_in;
   logic signed [23:0] wrap_ff, wrap_in;
   logic signed [32:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0] cz_ff, cz_in;
   logic               flip_ff, flip_in;
   logic signed [15:0] sin_yaw_ff, sin_yaw_in, cos_yaw_ff, cos_yaw_in;
   logic signed [15:0] sin_pit_ff, sin_pit_in, cos_pit_ff, cos_pit_in;
   logic signed [15:0] front_ff [3];
   logic signed [15:0] front_in [3];
   logic signed [15:0] up_ff [3];
   logic signed [15:0] up_in [3];
   logic signed [32:0] mprod_ff, mprod_in, acc_ff, acc_in;
   logic [22:0]        vel_ff, vel_in;
   logic signed [39:0] mv_ff, mv_in;
   logic [RSP_W-1:0]   out_ff, out_in;

   // Helper logic.
   logic signed [32:0] look_step, wrap_pre_w, pitch_w;
   logic signed [23:0] wrap_sub;
   logic signed [14:0] cangle;
   logic signed [25:0] z0, atan_v;
   logic signed [32:0] dx, dy;
   logic signed [15:0] cos_r, sin_r;
   logic signed [15:0] mul_a, mul_b;
   slot_type           slot;
   logic signed [15:0] vec_v;
   logic signed [39:0] d40;
   logic signed [PS-1:0] d_ext, pos_sum;
   logic signed [16:0] speed_sum;
   logic signed [15:0] csr_yaw;
   logic [14:0]        csr_speed;
   logic [31:0]        pos32 [3];
   logic signed [PW-1:0] pos_wide [3];

   assign status.look_zero = (lx_ff == '0) && (ly_ff == '0);

   assign look_step  = (prod_ff + 33'sd512) >>> 10;
   assign wrap_pre_w = 33'(yaw_ff) + look_step + 33'sd11520;
   assign pitch_w    = 33'(pitch_ff) - look_step;
   assign wrap_sub   = 24'(YAW_SPAN) <<< (3'(WRAP_STEPS - 1) - cmd.cnt[2:0]);

   assign cangle = cmd.phase ? 15'(pitch_ff) : yaw_ff;
   assign z0     = 26'(cangle) <<< 10;
   assign atan_v = 26'(ATAN_TABLE[cmd.cnt]);
   assign dx     = cy_ff >>> cmd.cnt;
   assign dy     = cx_ff >>> cmd.cnt;
   assign cos_r  = flip_ff ? -q16_sat(cx_ff) : q16_sat(cx_ff);
   assign sin_r  = flip_ff ? -q16_sat(cy_ff) : q16_sat(cy_ff);

   always_comb begin
      unique case (cmd.cnt[2:0])
         3'd0:    begin mul_a = cos_yaw_ff;  mul_b = cos_pit_ff; end
         3'd1:    begin mul_a = sin_yaw_ff;  mul_b = cos_pit_ff; end
         3'd2:    begin mul_a = -cos_yaw_ff; mul_b = sin_pit_ff; end
         3'd3:    begin mul_a = cos_yaw_ff;  mul_b = front_ff[0]; end
         3'd4:    begin mul_a = -sin_yaw_ff; mul_b = front_ff[2]; end
         3'd5:    begin mul_a = -sin_yaw_ff; mul_b = sin_pit_ff; end
         default: begin mul_a = '0;          mul_b = '0; end
      endcase
   end

   assign slot = slot_info(cmd.cnt[3:0]);

   always_comb begin
      unique case (slot.kind)
         VEC_FRONT: vec_v = front_ff[slot.axis];
         VEC_RIGHT: begin
            unique case (slot.axis)
               2'd0:    vec_v = -sin_yaw_ff;
               2'd2:    vec_v = cos_yaw_ff;
               default: vec_v = '0;
            endcase
         end
         default:   vec_v = 16'(ONE_Q14);
      endcase
   end

   assign d40     = (mv_ff + 40'sd8192) >>> 14;
   assign d_ext   = PS'(d40);
   assign pos_sum = slot.neg ? PS'(pos_ff[slot.axis]) - d_ext
                             : PS'(pos_ff[slot.axis]) + d_ext;

   assign speed_sum = $signed({2'b00, speed_ff}) + (17'(scroll_ff) <<< 7);

   always_comb begin
      csr_yaw = 16'($signed(csr_data[14:0]));
      if (csr_yaw >= 16'sd11520)       csr_yaw = csr_yaw - 16'sd23040;
      else if (csr_yaw < -16'sd11520)  csr_yaw = csr_yaw + 16'sd23040;
   end

   always_comb begin
      csr_speed = csr_data[14:0];
      if (csr_speed < 15'(SPEED_MIN))      csr_speed = 15'(SPEED_MIN);
      else if (csr_speed > 15'(SPEED_MAX)) csr_speed = 15'(SPEED_MAX);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pos_wide[k] = PW'(pos_ff[k]);
         pos32[k]    = pos_wide[k][31:0];
      end
   end

   always_comb begin
      lx_in = lx_ff;  ly_in = ly_ff;  keys_in = keys_ff;
      scroll_in = scroll_ff;  dt_in = dt_ff;
      sens_in = sens_ff;  yaw_in = yaw_ff;  pitch_in = pitch_ff;  speed_in = speed_ff;
      pos_in = pos_ff;
      prod_in = prod_ff;  wrap_in = wrap_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;  flip_in = flip_ff;
      sin_yaw_in = sin_yaw_ff;  cos_yaw_in = cos_yaw_ff;
      sin_pit_in = sin_pit_ff;  cos_pit_in = cos_pit_ff;
      front_in = front_ff;  up_in = up_ff;
      mprod_in = mprod_ff;  acc_in = acc_ff;
      vel_in = vel_ff;  mv_in = mv_ff;  out_in = out_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            lx_in     = req_tdata[15:0];
            ly_in     = req_tdata[31:16];
            keys_in   = req_tdata[37:32];
            scroll_in = req_tdata[45:38];
            dt_in     = req_tdata[61:46];
         end
         OP_CSR: begin
            unique case (csr_index)
               REG_LOOK_SENS:   sens_in  = csr_data;
               REG_START_SPEED: speed_in = csr_speed;
               REG_START_YAW:   yaw_in   = 15'(csr_yaw);
               default:         sens_in  = sens_ff;
            endcase
         end
         OP_LOOKX: prod_in = 33'(lx_ff * $signed({1'b0, sens_ff}));
         OP_LOOKY: begin
            // Shift the sum into the non-negative range before the subtract steps.
            if (wrap_pre_w < 0) wrap_in = 24'(wrap_pre_w + 33'sd2949120);
            else                wrap_in = 24'(wrap_pre_w);
            prod_in = 33'(ly_ff * $signed({1'b0, sens_ff}));
         end
         OP_PITCH: begin
            if (pitch_w > 33'(PITCH_LIM))       pitch_in = 14'(PITCH_LIM);
            else if (pitch_w < -33'(PITCH_LIM)) pitch_in = -14'(PITCH_LIM);
            else                                pitch_in = 14'(pitch_w);
         end
         OP_WRAP: begin
            if (wrap_ff >= wrap_sub) wrap_in = wrap_ff - wrap_sub;
         end
         OP_WRAPEND: yaw_in = 15'(wrap_ff - 24'sd11520);
         OP_CINIT: begin
            cx_in = 33'(CORDIC_K);
            cy_in = '0;
            // Angles beyond a right angle are folded and the results negated.
            if (z0 > 26'(DEG90)) begin
               cz_in = z0 - 26'(DEG180);  flip_in = 1'b1;
            end else if (z0 < -26'(DEG90)) begin
               cz_in = z0 + 26'(DEG180);  flip_in = 1'b1;
            end else begin
               cz_in = z0;  flip_in = 1'b0;
            end
         end
         OP_CSTEP: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - dx;  cy_in = cy_ff + dy;  cz_in = cz_ff - atan_v;
            end else begin
               cx_in = cx_ff + dx;  cy_in = cy_ff - dy;  cz_in = cz_ff + atan_v;
            end
         end
         OP_CEND: begin
            if (cmd.phase) begin
               sin_pit_in = sin_r;  cos_pit_in = cos_r;
            end else begin
               sin_yaw_in = sin_r;  cos_yaw_in = cos_r;
            end
         end
         OP_BASIS: begin
            mprod_in = 33'(mul_a * mul_b);
            unique case (cmd.cnt[2:0])
               3'd1: front_in[0] = q14_sat(mprod_ff);
               3'd2: begin
                  front_in[2] = q14_sat(mprod_ff);
                  front_in[1] = sin_pit_ff;
               end
               3'd3: up_in[0] = q14_sat(mprod_ff);
               3'd4: acc_in = mprod_ff;
               3'd5: up_in[1] = q14_sat(acc_ff - mprod_ff);
               3'd6: up_in[2] = q14_sat(mprod_ff);
               default: acc_in = acc_ff;
            endcase
         end
         OP_VEL: vel_in = 23'(((31'(speed_ff) * 31'(dt_ff)) + 31'd128) >> 8);
         OP_MMUL: mv_in = 40'(vec_v * $signed({1'b0, vel_ff}));
         OP_MADD: begin
            if (keys_ff[slot.key]) begin
               if (pos_sum > POS_HI)      pos_in[slot.axis] = POS_BITS'(POS_HI);
               else if (pos_sum < POS_LO) pos_in[slot.axis] = POS_BITS'(POS_LO);
               else                       pos_in[slot.axis] = POS_BITS'(pos_sum);
            end
         end
         OP_SPEED: begin
            if (scroll_ff != '0) begin
               if (speed_sum < 17'(SPEED_MIN))      speed_in = 15'(SPEED_MIN);
               else if (speed_sum > 17'(SPEED_MAX)) speed_in = 15'(SPEED_MAX);
               else                                 speed_in = 15'(speed_sum);
            end
         end
         OP_OUT: begin
            out_in = {4'b0000, speed_ff, pitch_ff, yaw_ff,
                      up_ff[2], up_ff[1], up_ff[0],
                      front_ff[2], front_ff[1], front_ff[0],
                      pos32[2], pos32[1], pos32[0]};
         end
         default: out_in = out_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff  <= SENS_RESET;
         yaw_ff   <= YAW_RESET;
         pitch_ff <= '0;
         speed_ff <= SPEED_RESET;
         for (int k = 0; k < 3; k++) pos_ff[k] <= '0;
      end else begin
         sens_ff  <= sens_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         speed_ff <= speed_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      lx_ff <= lx_in;  ly_ff <= ly_in;  keys_ff <= keys_in;
      scroll_ff <= scroll_in;  dt_ff <= dt_in;
      prod_ff <= prod_in;  wrap_ff <= wrap_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;  flip_ff <= flip_in;
      sin_yaw_ff <= sin_yaw_in;  cos_yaw_ff <= cos_yaw_in;
      sin_pit_ff <= sin_pit_in;  cos_pit_ff <= cos_pit_in;
      front_ff <= front_in;  up_ff <= up_in;
      mprod_ff <= mprod_in;  acc_ff <= acc_in;
      vel_ff <= vel_in;  mv_ff <= mv_in;  out_ff <= out_in;
   end

   assign rsp_tdata = out_ff;

endmodule
`default_nettype wire

// ===== rtl/fly_camera_pose_integrator.sv =====
// Top level of the fly-camera pose integrator.
//
//  channel  direction  transfer when               contents
//  req      in         req_tvalid & req_tready     one frame: look, keys, scroll, frame time
//  rsp      out        rsp_tvalid & rsp_tready     pose after the frame
//  csr      in         csr_valid & csr_ready       register index and write data
//
// A frame with a look delta goes through the eight-step yaw wrap, the two CORDIC passes
// and the basis rebuild before the 14 serial moves; a frame without look goes straight
// to the moves. After reset, and after a start_yaw write, the basis is rebuilt before
// the next transfer.
// A stalled result waits in its register while the next frame is already worked on.
`default_nettype none
module fly_camera_pose_integrator #(
   parameter int POS_BITS     = fcpi_pkg::POS_BITS_DEF,
   parameter int CORDIC_STEPS = fcpi_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // look_x, look_y, held_keys, scroll_y, delta_time, zero fill
   input  wire logic [fcpi_pkg::REQ_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // pos_x, pos_y, pos_z, front_x, front_y, front_z, up_x, up_y, up_z,
   // yaw_out, pitch_out, speed_out, zero fill
   output logic [fcpi_pkg::RSP_W-1:0]           rsp_tdata,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fcpi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fcpi_pkg::CSR_DATA_W-1:0] csr_data
);
   import fcpi_pkg::*;

   cmd_type    cmd;
   status_type status;

   fcpi_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .status     (status),
      .cmd        (cmd)
   );

   fcpi_datapath #(
      .POS_BITS(POS_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== rtl/fcpi_checker.sv =====
// Port-level checks of the fly-camera pose integrator and their binding.
`default_nettype none
module fcpi_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [fcpi_pkg::RSP_W-1:0]      rsp_tdata,
   input wire logic                           csr_valid,
   input wire logic                           csr_ready
);
   import fcpi_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before its transfer");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !csr_ready)
      else $error("new transfer taken while a frame is in work");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[235:221] >= 15'(SPEED_MIN)
                  && rsp_tdata[235:221] <= 15'(SPEED_MAX))
      else $error("speed out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[220:207]) <= 14'sd5696
                  && $signed(rsp_tdata[220:207]) >= -14'sd5696)
      else $error("pitch out of range");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !(req_tvalid && req_tready))
      else $error("register write and frame taken together");

endmodule

bind fly_camera_pose_integrator fcpi_checker u_fcpi_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the fly-camera pose integrator.
`timescale 1ns / 1ps
module testbench;
   import fcpi_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int NFIELDS = 12;
   localparam int FIELD_W [NFIELDS] = '{32, 32, 32, 16, 16, 16, 16, 16, 16, 15, 14, 15};

   typedef struct {
      longint f [NFIELDS];
   } pose_t;

   typedef struct {
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic [5:0]         keys;
      logic signed [7:0]  scroll;
      logic [15:0]        dt;
   } frame_t;

   typedef struct {
      frame_t fr;
      bit     fixed;
      longint yaw;
      longint pitch;
      longint speed;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pose_t pending_poses [$];
   int    errors = 0;
   int    poses_seen = 0;
   bit    no_idle = 0;

   // Camera state as the block should hold it.
   longint sens, yaw, pitch, speed;
   longint pos [3];
   longint basis [9];

   fly_camera_pose_integrator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("FAIL fly_camera_pose_integrator");
      $finish;
   end

   function automatic longint rnd_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint wrap_angle(longint v);
      longint r;
      r = (v + YAW_HALF) % YAW_SPAN;
      if (r < 0) r += YAW_SPAN;
      return r - YAW_HALF;
   endfunction

   task automatic sine_cosine(input longint ang, output longint sn, output longint cs);
      longint z, x, y, dx, dy;
      bit flip;
      z = ang * 1024;
      x = longint'(CORDIC_K);
      y = 0;
      flip = 0;
      if (z > DEG90) begin
         z -= DEG180;
         flip = 1;
      end else if (z < -DEG90) begin
         z += DEG180;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TABLE[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TABLE[i]);
         end
      end
      cs = clip(rnd_shr(x, 16), -ONE_Q14, ONE_Q14);
      sn = clip(rnd_shr(y, 16), -ONE_Q14, ONE_Q14);
      if (flip) begin
         cs = -cs;
         sn = -sn;
      end
   endtask

   function automatic longint q14(longint v);
      return clip(rnd_shr(v, 14), -ONE_Q14, ONE_Q14);
   endfunction

   task automatic rebuild_basis();
      longint sy, cy, sp, cp;
      sine_cosine(yaw, sy, cy);
      sine_cosine(pitch, sp, cp);
      basis[0] = q14(cy * cp);
      basis[1] = sp;
      basis[2] = q14(sy * cp);
      basis[3] = -sy;
      basis[4] = 0;
      basis[5] = cy;
      basis[6] = q14(-basis[5] * basis[1]);
      basis[7] = q14(basis[5] * basis[0] - basis[3] * basis[2]);
      basis[8] = q14(basis[3] * basis[1]);
   endtask

   task automatic move_axis(int k, longint d);
      pos[k] = clip(pos[k] + d, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1);
   endtask

   task automatic move_along(int vec, longint vel, bit add);
      longint d;
      for (int k = 0; k < 3; k++) begin
         d = rnd_shr(basis[vec + k] * vel, 14);
         move_axis(k, add ? d : -d);
      end
   endtask

   task automatic apply_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
         REG_LOOK_SENS: sens = longint'(v);
         REG_START_SPEED: speed = clip(longint'(v[14:0]), SPEED_MIN, SPEED_MAX);
         REG_START_YAW: begin
            yaw = wrap_angle(longint'($signed(v[14:0])));
            rebuild_basis();
         end
         default: ;
      endcase
   endtask

   task automatic advance_pose(input frame_t fr, output pose_t p);
      longint vel;
      if (fr.lx != 0 || fr.ly != 0) begin
         yaw = wrap_angle(yaw + rnd_shr(longint'(fr.lx) * sens, 10));
         pitch = clip(pitch - rnd_shr(longint'(fr.ly) * sens, 10), -PITCH_LIM, PITCH_LIM);
         rebuild_basis();
      end
      vel = (speed * longint'(fr.dt) + 128) >>> 8;
      if (fr.keys[0]) move_along(0, vel, 1);
      if (fr.keys[1]) move_along(0, vel, 0);
      if (fr.keys[2]) move_along(3, vel, 0);
      if (fr.keys[3]) move_along(3, vel, 1);
      if (fr.keys[4]) move_axis(1, vel);
      if (fr.keys[5]) move_axis(1, -vel);
      if (fr.scroll != 0)
         speed = clip(speed + longint'(fr.scroll) * 128, SPEED_MIN, SPEED_MAX);
      for (int k = 0; k < 3; k++) begin
         p.f[k] = pos[k];
         p.f[3 + k] = basis[k];
         p.f[6 + k] = basis[6 + k];
      end
      p.f[9] = yaw;
      p.f[10] = pitch;
      p.f[11] = speed;
      for (int k = 0; k < NFIELDS; k++)
         p.f[k] &= (longint'(1) <<< FIELD_W[k]) - 1;
   endtask

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives from the next falling edge; returns just after the accepting rising edge.
   task automatic send_frame(input frame_t fr, output pose_t p);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, fr.dt, fr.scroll, fr.keys, fr.ly, fr.lx};
      do @(posedge clock); while (!req_tready);
      advance_pose(fr, p);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic frame_t random_frame(int bias);
      frame_t fr;
      int r;
      fr.lx = 16'($urandom);
      fr.ly = 16'($urandom);
      r = $urandom_range(0, 9);
      if (r < 3) begin
         fr.lx = 0;
         fr.ly = 0;
      end else if (r < 7) begin
         fr.lx = $signed(16'($urandom_range(0, 400))) - 16'sd200;
         fr.ly = $signed(16'($urandom_range(0, 400))) - 16'sd200;
      end
      fr.keys = 6'($urandom);
      fr.dt = 16'($urandom);
      fr.scroll = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'sd0;
      // Frames with a fixed key pattern at full frame time push the position toward saturation.
      if (bias != 0 && $urandom_range(0, 1) == 0) begin
         fr.keys = 6'(bias);
         fr.dt = 16'hFFFF;
      end
      return fr;
   endfunction

   // Result side: ready with random gaps and one long hold-off.
   initial begin
      int gap;
      bit held;
      held = 0;
      forever begin
         @(negedge clock);
         if (!held && poses_seen >= 150) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            held = 1;
            rsp_tready <= 1'b1;
         end else begin
            gap = idle_gap();
            if (gap == 0) rsp_tready <= 1'b1;
            else begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      pose_t want;
      longint got;
      int lsb;
      if (!reset && rsp_tvalid && rsp_tready) begin
         poses_seen++;
         if (pending_poses.size() == 0) begin
            errors++;
            $display("%0t: pose transfer with none expected, data %h", $time, rsp_tdata);
         end else begin
            want = pending_poses.pop_front();
            lsb = 0;
            for (int k = 0; k < NFIELDS; k++) begin
               got = longint'(rsp_tdata >> lsb) & ((longint'(1) <<< FIELD_W[k]) - 1);
               if (got !== want.f[k]) begin
                  errors++;
                  $display("%0t: field %0d expected %h got %h", $time, k, want.f[k], got);
               end
               lsb += FIELD_W[k];
            end
         end
      end
   end

   row_t directed [] = '{
      '{'{16'sd0, 16'sd0, 6'h00, 8'sd0, 16'd0}, 1, -5760, 0, 1280},
      '{'{16'sd0, 16'sd0, 6'h00, 8'sd127, 16'd0}, 1, -5760, 0, 17536},
      '{'{16'sd0, 16'sd0, 6'h00, 8'sd127, 16'd0}, 1, -5760, 0, 25600},
      '{'{16'sd0, 16'sd0, 6'h00, -8'sd128, 16'd0}, 1, -5760, 0, 9216},
      '{'{16'sd0, 16'sd0, 6'h00, -8'sd128, 16'd0}, 1, -5760, 0, 128},
      '{'{16'sd0, 16'sd0, 6'h00, 8'sd10, 16'd0}, 1, -5760, 0, 1408},
      '{'{16'sd0, -16'sd32768, 6'h00, 8'sd0, 16'd0}, 1, -5760, 5696, 1408},
      '{'{16'sd0, 16'sd32767, 6'h00, 8'sd0, 16'd0}, 1, -5760, -5696, 1408},
      '{'{16'sd32767, 16'sd0, 6'h00, 8'sd0, 16'd100}, 0, 0, 0, 0},
      '{'{-16'sd32768, 16'sd0, 6'h00, 8'sd0, 16'd100}, 0, 0, 0, 0},
      '{'{16'sd1, -16'sd1, 6'h00, 8'sd0, 16'd0}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h01, 8'sd0, 16'hFFFF}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h02, 8'sd0, 16'hFFFF}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h04, 8'sd0, 16'hFFFF}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h08, 8'sd0, 16'hFFFF}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h10, 8'sd0, 16'hFFFF}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h20, 8'sd0, 16'hFFFF}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h3F, 8'sd0, 16'hFFFF}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h03, 8'sd0, 16'd0}, 0, 0, 0, 0},
      '{'{16'sd0, 16'sd0, 6'h3F, 8'sd1, 16'd1}, 0, 0, 0, 0},
      '{'{-16'sd1, 16'sd1, 6'h15, 8'sd0, 16'h8000}, 0, 0, 0, 0}
   };

   initial begin
      pose_t p;
      logic [15:0] settings [5][3];
      int bias [5];
      settings = '{
         '{16'd6554, 16'd1280, 16'hE980},
         '{16'd0, 16'd25600, 16'd11519},
         '{16'hFFFF, 16'd128, 16'hD300},
         '{16'd3000, 16'h7FFF, 16'h3FFF},
         '{16'd100, 16'd0, 16'd4096}
      };
      bias = '{0, 16, 0, 34, 0};
      sens = longint'(SENS_RESET);
      speed = longint'(SPEED_RESET);
      yaw = longint'(YAW_RESET);
      pitch = 0;
      pos = '{0, 0, 0};
      rebuild_basis();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_frame(directed[i].fr, p);
         if (directed[i].fixed) begin
            p.f[9] = directed[i].yaw & 16'h7FFF;
            p.f[10] = directed[i].pitch & 16'h3FFF;
            p.f[11] = directed[i].speed;
         end
         pending_poses.push_back(p);
      end
      wait_quiet();
      write_register(REG_UNUSED, 16'hFFFF);

      for (int ph = 0; ph < 5; ph++) begin
         write_register(REG_LOOK_SENS, settings[ph][0]);
         write_register(REG_START_SPEED, settings[ph][1]);
         write_register(REG_START_YAW, settings[ph][2]);
         for (int n = 0; n < 186; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_frame(random_frame(bias[ph]), p);
            pending_poses.push_back(p);
         end
         no_idle = 0;
         wait_quiet();
      end

      if (errors == 0)
         $display("PASS fly_camera_pose_integrator");
      else
         $display("FAIL fly_camera_pose_integrator");
      $finish;
   end

endmodule
